>>> rtl/core/gbcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcr_pkg
// Shared constants, state type and pivot search for the GF(2) column reducer.
// ----------------------------------------------------------------------------
package gbcr_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int STORE_DEPTH = 64;
  localparam int CAPACITY    = (MAX_COLUMNS > STORE_DEPTH) ? STORE_DEPTH : MAX_COLUMNS;

  localparam int MASK_W = 64;
  localparam int ROW_W  = 6;
  localparam int CNT_W  = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_OWN,
    ST_COL,
    ST_WRITE
  } state_t;

  // highest set row, zero for an empty column
  function automatic logic [ROW_W-1:0] top_bit(input logic [MASK_W-1:0] v);
    logic [ROW_W-1:0] p;
    p = '0;
    for (int r = 0; r < MASK_W; r++) begin
      if (v[r]) begin
        p = ROW_W'(r);
      end
    end
    return p;
  endfunction

endpackage

>>> rtl/core/gbcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/gf2_boundary_column_reduction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_boundary_column_reduction
// Persistence column reduction over GF(2): each incoming boundary column is
// reduced against stored columns owning its pivot, then stored.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     start / busy       in_first_column, in_boundary_mask
//  result    out_valid strobe   out_column_index, out_has_pivot, out_pivot_row,
//                               out_reduced_mask, out_overflow
//
//  A column taking k additions (k <= 63) stays busy for them, a final pivot
//  search and the write; each addition is pivot search, owner RAM read,
//  column RAM read and XOR. An overflow column is answered without going busy.
//  The result strobe is high in the first cycle with busy low again, or in
//  the cycle after an overflow transaction. Reset is synchronous and clears
//  the pivot table and column count; the column and owner RAMs need no
//  clearing.
// ----------------------------------------------------------------------------
module gf2_boundary_column_reduction (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_first_column,
  input  logic [gbcr_pkg::MASK_W-1:0]  in_boundary_mask,
  output logic                         out_valid,
  output logic [gbcr_pkg::ROW_W-1:0]   out_column_index,
  output logic                         out_has_pivot,
  output logic [gbcr_pkg::ROW_W-1:0]   out_pivot_row,
  output logic [gbcr_pkg::MASK_W-1:0]  out_reduced_mask,
  output logic                         out_overflow
);

  import gbcr_pkg::*;

  state_t             state_r, state_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic [ROW_W-1:0]   idx_r, idx_nxt;
  logic [ROW_W-1:0]   piv_r, piv_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [MASK_W-1:0]  pvalid_r, pvalid_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic [ROW_W-1:0]   ocol_r, ocol_nxt;
  logic               ohas_r, ohas_nxt;
  logic [ROW_W-1:0]   orow_r, orow_nxt;
  logic [MASK_W-1:0]  omask_r, omask_nxt;
  logic               oovf_r, oovf_nxt;

  logic [ROW_W-1:0]   top;
  logic [CNT_W-1:0]   cnt_eff;
  logic [MASK_W-1:0]  low_mask;
  logic               nz;

  logic               col_we;
  logic [MASK_W-1:0]  col_rdata;
  logic               own_we;
  logic [ROW_W-1:0]   own_rdata;

  gbcr_ram #(.WIDTH(MASK_W), .DEPTH(STORE_DEPTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (idx_r),
    .wdata (mask_r),
    .raddr (own_rdata),
    .rdata (col_rdata)
  );

  gbcr_ram #(.WIDTH(ROW_W), .DEPTH(STORE_DEPTH)) u_own_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (piv_r),
    .wdata (idx_r),
    .raddr (top),
    .rdata (own_rdata)
  );

  assign top = top_bit(mask_r);
  assign nz  = |mask_r;
  assign cnt_eff = in_first_column ? '0 : count_r;

  always_comb begin
    for (int r = 0; r < MASK_W; r++) begin
      low_mask[r] = (CNT_W'(r) < cnt_eff);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mask_nxt   = mask_r;
    idx_nxt    = idx_r;
    piv_nxt    = piv_r;
    count_nxt  = count_r;
    pvalid_nxt = pvalid_r;
    ovalid_nxt = 1'b0;
    ocol_nxt   = ocol_r;
    ohas_nxt   = ohas_r;
    orow_nxt   = orow_r;
    omask_nxt  = omask_r;
    oovf_nxt   = oovf_r;
    col_we     = 1'b0;
    own_we     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_first_column) begin
            pvalid_nxt = '0;
            count_nxt  = '0;
          end
          if (cnt_eff >= CNT_W'(CAPACITY)) begin
            ovalid_nxt = 1'b1;
            ocol_nxt   = '0;
            ohas_nxt   = 1'b0;
            orow_nxt   = '0;
            omask_nxt  = '0;
            oovf_nxt   = 1'b1;
          end else begin
            idx_nxt   = cnt_eff[ROW_W-1:0];
            mask_nxt  = in_boundary_mask & low_mask;
            state_nxt = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        piv_nxt = top;
        if (!nz || !pvalid_r[top]) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_OWN;
        end
      end
      ST_OWN: begin
        state_nxt = ST_COL;
      end
      ST_COL: begin
        mask_nxt  = mask_r ^ col_rdata;
        state_nxt = ST_FIND;
      end
      ST_WRITE: begin
        col_we    = 1'b1;
        own_we    = nz;
        if (nz) begin
          pvalid_nxt[piv_r] = 1'b1;
        end
        count_nxt  = CNT_W'(idx_r) + CNT_W'(1);
        ovalid_nxt = 1'b1;
        ocol_nxt   = idx_r;
        ohas_nxt   = nz;
        orow_nxt   = nz ? piv_r : '0;
        omask_nxt  = mask_r;
        oovf_nxt   = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      pvalid_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pvalid_r <= pvalid_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    idx_r   <= idx_nxt;
    piv_r   <= piv_nxt;
    ocol_r  <= ocol_nxt;
    ohas_r  <= ohas_nxt;
    orow_r  <= orow_nxt;
    omask_r <= omask_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ovalid_r;
  assign out_column_index = ocol_r;
  assign out_has_pivot    = ohas_r;
  assign out_pivot_row    = orow_r;
  assign out_reduced_mask = omask_r;
  assign out_overflow     = oovf_r;

endmodule
